>>> rtl/mc_pkg.sv
// Shared types, constants and the Morse tree tables of the codec.
package mc_pkg;

    localparam int MAX_CODE_LEN = 6;
    localparam int BYTE_W       = 8;
    localparam int NODE_W       = 7;
    localparam int NODE_COUNT   = 127;
    localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
    localparam int PIDX_W       = $clog2(NODE_W);

    // nodes numbered below this (depth under MAX_CODE_LEN) may still take a child
    localparam logic [8:0] DEPTH_LIMIT = 9'((1 << MAX_CODE_LEN) - 1);

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [NODE_W-1:0] node_t;
    typedef logic [LEN_W-1:0]  len_t;

    localparam byte_t CH_HASH  = 8'd35;
    localparam byte_t CH_SPACE = 8'd32;
    localparam byte_t CH_DOT   = 8'd46;
    localparam byte_t CH_DASH  = 8'd45;
    localparam byte_t CH_NONE  = 8'd0;

    typedef struct packed {
        logic  hit;
        node_t node;
    } enc_rom_t;

    // one accepted item as handed from the front end to the emitter
    typedef struct packed {
        logic     enc;
        logic     has;
        logic     use_rom;
        byte_t    lit;
        enc_rom_t rom;
        byte_t    sym;
    } stage_t;

    // heap-ordered tree: root 0, dot child 2n+1, dash child 2n+2; CH_NONE = no node
    function automatic byte_t node_sym(input node_t n);
        byte_t s;
        case (n)
            7'd0:   s = CH_HASH;
            7'd1:   s = "E";
            7'd2:   s = "T";
            7'd3:   s = "I";
            7'd4:   s = "A";
            7'd5:   s = "N";
            7'd6:   s = "M";
            7'd7:   s = "S";
            7'd8:   s = "U";
            7'd9:   s = "R";
            7'd10:  s = "W";
            7'd11:  s = "D";
            7'd12:  s = "K";
            7'd13:  s = "G";
            7'd14:  s = "O";
            7'd15:  s = "H";
            7'd16:  s = "V";
            7'd17:  s = "F";
            7'd18:  s = CH_HASH;
            7'd19:  s = "L";
            7'd20:  s = CH_HASH;
            7'd21:  s = "P";
            7'd22:  s = "J";
            7'd23:  s = "B";
            7'd24:  s = "X";
            7'd25:  s = "C";
            7'd26:  s = "Y";
            7'd27:  s = "Z";
            7'd28:  s = "Q";
            7'd29:  s = CH_HASH;
            7'd30:  s = CH_HASH;
            7'd31:  s = "5";
            7'd32:  s = "4";
            7'd34:  s = "3";
            7'd37:  s = CH_HASH;
            7'd38:  s = "2";
            7'd39:  s = "&";
            7'd40:  s = CH_HASH;
            7'd41:  s = "+";
            7'd44:  s = CH_HASH;
            7'd46:  s = "1";
            7'd47:  s = "6";
            7'd48:  s = "=";
            7'd49:  s = "/";
            7'd52:  s = CH_HASH;
            7'd53:  s = "(";
            7'd55:  s = "7";
            7'd56:  s = CH_HASH;
            7'd58:  s = 8'd165;
            7'd59:  s = "8";
            7'd61:  s = "9";
            7'd62:  s = "0";
            7'd75:  s = "?";
            7'd76:  s = "_";
            7'd81:  s = 8'd34;
            7'd84:  s = ".";
            7'd89:  s = "@";
            7'd93:  s = 8'd39;
            7'd96:  s = "-";
            7'd105: s = ";";
            7'd108: s = ")";
            7'd106: s = "!";
            7'd114: s = ",";
            7'd119: s = ":";
            default: s = CH_NONE;
        endcase
        return s;
    endfunction

    // character to tree node; space and hash map onto the root
    function automatic enc_rom_t char_node(input byte_t b);
        enc_rom_t r;
        r.hit  = 1'b1;
        r.node = 7'd0;
        case (b)
            CH_SPACE, CH_HASH: r.node = 7'd0;
            "E": r.node = 7'd1;
            "T": r.node = 7'd2;
            "I": r.node = 7'd3;
            "A": r.node = 7'd4;
            "N": r.node = 7'd5;
            "M": r.node = 7'd6;
            "S": r.node = 7'd7;
            "U": r.node = 7'd8;
            "R": r.node = 7'd9;
            "W": r.node = 7'd10;
            "D": r.node = 7'd11;
            "K": r.node = 7'd12;
            "G": r.node = 7'd13;
            "O": r.node = 7'd14;
            "H": r.node = 7'd15;
            "V": r.node = 7'd16;
            "F": r.node = 7'd17;
            "L": r.node = 7'd19;
            "P": r.node = 7'd21;
            "J": r.node = 7'd22;
            "B": r.node = 7'd23;
            "X": r.node = 7'd24;
            "C": r.node = 7'd25;
            "Y": r.node = 7'd26;
            "Z": r.node = 7'd27;
            "Q": r.node = 7'd28;
            "5": r.node = 7'd31;
            "4": r.node = 7'd32;
            "3": r.node = 7'd34;
            "2": r.node = 7'd38;
            "&": r.node = 7'd39;
            "+": r.node = 7'd41;
            "1": r.node = 7'd46;
            "6": r.node = 7'd47;
            "=": r.node = 7'd48;
            "/": r.node = 7'd49;
            "(": r.node = 7'd53;
            "7": r.node = 7'd55;
            8'd165: r.node = 7'd58;
            "8": r.node = 7'd59;
            "9": r.node = 7'd61;
            "0": r.node = 7'd62;
            "?": r.node = 7'd75;
            "_": r.node = 7'd76;
            8'd34: r.node = 7'd81;
            ".": r.node = 7'd84;
            "@": r.node = 7'd89;
            8'd39: r.node = 7'd93;
            "-": r.node = 7'd96;
            ";": r.node = 7'd105;
            "!": r.node = 7'd106;
            ")": r.node = 7'd108;
            ",": r.node = 7'd114;
            ":": r.node = 7'd119;
            default: r.hit = 1'b0;
        endcase
        return r;
    endfunction

    // code length = depth of the node, i.e. leading-one position of node+1
    function automatic len_t path_len(input node_t n);
        node_t p;
        int    d;
        p = n + 7'd1;
        d = 0;
        for (int i = 1; i < NODE_W; i++)
        begin
            if (p[i])
                d = i;
        end
        if (d > MAX_CODE_LEN)
            d = MAX_CODE_LEN;
        return LEN_W'(d);
    endfunction

endpackage

>>> rtl/mc_in_if.sv
// Input channel: one character or Morse symbol per item.
interface mc_in_if
    import mc_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

>>> rtl/mc_out_if.sv
// Output channel: one emitted byte per item, with end-of-group flag.
interface mc_out_if
    import mc_pkg::*;
();
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

>>> rtl/morse_codec_unit.sv
// Top level of the Morse codec: configuration, front end and emitter.
// An accepted item is registered in the stage buffer, each result in the output register.
// An encoded character gives one result per code symbol and a closing space,
// the emitter stepping one symbol per cycle while the output register is free.
// A new item is taken in the cycle its predecessor's last result is emitted, or at once for an item with none.
// Reset (rst_n, async low): encode direction, tree at root, flags clear.
module morse_codec_unit
    import mc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_data,
    mc_in_if.sink     in_chan,
    mc_out_if.source  out_chan
);

    // single item buffer between the table reads and the emitter
    logic   busy;
    logic   done;
    stage_t stage;

    // front end: holds direction, walks the tree on dots and dashes and
    // reads both tables (char to node, node to char) in the accept cycle
    mc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_chan  (in_chan),
        .done     (done),
        .busy     (busy),
        .stage    (stage)
    );

    // emitter: one result per cycle into the output register while it is free; frees the
    // buffer on the item's last result, or at once for an item with none
    mc_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .busy     (busy),
        .stage    (stage),
        .done     (done),
        .out_chan (out_chan)
    );

endmodule

>>> rtl/mc_front.sv
// Front end: decoder tree walk, table reads and the single stage buffer.
module mc_front
    import mc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_data,
    mc_in_if.sink     in_chan,
    input  logic      done,
    output logic      busy,
    output stage_t    stage
);

    logic   direction_reg;
    logic   busy_reg,  busy_next;
    node_t  node_reg,  node_next;
    logic   inv_reg,   inv_next;
    logic   after_reg, after_next;
    stage_t stage_reg;

    logic   accept;
    logic   is_sym;
    logic   is_space;
    logic [7:0] child;
    logic   child_ok;
    logic   has_d;
    logic   use_rom_d;
    byte_t  lit_d;

    assign in_chan.ready = !busy_reg || done;
    assign accept        = in_chan.valid && in_chan.ready;
    assign busy          = busy_reg;
    assign stage         = stage_reg;

    assign is_sym   = (in_chan.in_byte == CH_DOT) || (in_chan.in_byte == CH_DASH);
    assign is_space = (in_chan.in_byte == CH_SPACE);
    assign child    = {node_reg, 1'b0} + ((in_chan.in_byte == CH_DASH) ? 8'd2 : 8'd1);
    assign child_ok = ({2'b00, node_reg} < DEPTH_LIMIT)
                   && (child < 8'(NODE_COUNT))
                   && (node_sym(child[NODE_W-1:0]) != CH_NONE);

    always_comb
    begin
        node_next  = node_reg;
        inv_next   = inv_reg;
        after_next = after_reg;
        has_d      = 1'b0;
        use_rom_d  = 1'b0;
        lit_d      = CH_HASH;
        busy_next  = busy_reg;
        if (done)
            busy_next = 1'b0;
        if (accept)
        begin
            busy_next = 1'b1;
            if (direction_reg)
            begin
                if (is_sym)
                begin
                    after_next = 1'b0;
                    if (!inv_reg)
                    begin
                        if (child_ok)
                            node_next = child[NODE_W-1:0];
                        else
                            inv_next = 1'b1;
                    end
                end
                else if (is_space)
                begin
                    has_d = 1'b1;
                    if (after_reg)
                    begin
                        lit_d      = CH_SPACE;
                        after_next = 1'b0;
                    end
                    else
                    begin
                        // root reads back as hash from the node table
                        use_rom_d  = !inv_reg;
                        node_next  = '0;
                        inv_next   = 1'b0;
                        after_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            busy_reg      <= 1'b0;
            node_reg      <= '0;
            inv_reg       <= 1'b0;
            after_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                direction_reg <= cfg_data;
            busy_reg  <= busy_next;
            node_reg  <= node_next;
            inv_reg   <= inv_next;
            after_reg <= after_next;
        end
    end

    // synchronous table reads, captured with the item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.enc     <= !direction_reg;
            stage_reg.has     <= has_d;
            stage_reg.use_rom <= use_rom_d;
            stage_reg.lit     <= lit_d;
            stage_reg.rom     <= char_node(in_chan.in_byte);
            stage_reg.sym     <= node_sym(node_reg);
        end
    end

    a_node_exists: assert property (@(posedge clk) disable iff (!rst_n)
        node_sym(node_reg) != CH_NONE)
        else $error("tree position left the tree");

    a_after_at_root: assert property (@(posedge clk) disable iff (!rst_n)
        after_reg |-> (node_reg == '0) && !inv_reg)
        else $error("letter gap flag set away from root");

    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("accepted item not held");

endmodule

>>> rtl/mc_emit.sv
// Emitter: steps through one buffered item and fills the output register.
module mc_emit
    import mc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      busy,
    input  stage_t    stage,
    output logic      done,
    mc_out_if.source  out_chan
);

    len_t  pos_reg, pos_next;
    logic  ov_reg;
    byte_t ob_reg;
    logic  ol_reg;

    node_t             p;
    len_t              len;
    logic [PIDX_W-1:0] idx;
    logic              has;
    logic              is_last;
    byte_t             sym_byte;
    logic              out_free;
    logic              fire;

    assign p   = stage.rom.node + 7'd1;
    assign len = path_len(stage.rom.node);
    assign idx = PIDX_W'(len - LEN_W'(1) - pos_reg);

    always_comb
    begin
        if (stage.enc)
        begin
            has      = stage.rom.hit;
            is_last  = (pos_reg == len);
            sym_byte = is_last ? CH_SPACE : (p[idx] ? CH_DASH : CH_DOT);
        end
        else
        begin
            has      = stage.has;
            is_last  = 1'b1;
            sym_byte = stage.use_rom ? stage.sym : stage.lit;
        end
    end

    assign out_free = !ov_reg || out_chan.ready;
    assign fire     = busy && has && out_free;
    assign done     = busy && (!has || (out_free && is_last));

    always_comb
    begin
        pos_next = pos_reg;
        if (done)
            pos_next = '0;
        else if (fire)
            pos_next = pos_reg + LEN_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (out_free)
                ov_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ob_reg <= sym_byte;
            ol_reg <= is_last;
        end
    end

    assign out_chan.valid    = ov_reg;
    assign out_chan.out_byte = ob_reg;
    assign out_chan.last     = ol_reg;

    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (pos_reg == '0))
        else $error("symbol counter not parked");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LEN_W'(MAX_CODE_LEN))
        else $error("symbol counter overran code length");

endmodule

>>> test/morse_codec_unit_tb.sv
// Self-checking testbench of the Morse codec: encode and decode phases, random stalls.
module morse_codec_unit_tb;
    import mc_pkg::*;

    // Direction register values, written by name everywhere.
    typedef enum logic {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } codec_dir_e;

    // One emitted byte as the output channel carries it.
    typedef struct packed {
        byte_t out_byte;
        logic  last;
    } morse_sym_t;

    localparam int TREE_ENTRIES = 63;
    localparam int HOLD_CYCLES  = 400;    // long receiver hold-off, fills the block
    localparam int SETTLE       = 6;      // quiet cycles before a register write
    localparam int DRAIN        = 20;     // quiet cycles at the end of the run
    localparam int LIMIT        = 600000; // timeout, several times the slowest run

    // ------------------------------------------------------------------
    // Scoreboard: its own copy of the tree, the direction and the decode
    // state; predicts every accepted item and checks each result in order.
    // ------------------------------------------------------------------
    class codec_scoreboard;
        morse_sym_t  awaited_q[$];
        codec_dir_e  dir;
        node_t       node;
        bit          bad_code;
        bit          word_gap;
        byte_t       node_char[NODE_COUNT];
        bit          node_used[NODE_COUNT];
        string       char_code[256];
        bit          char_known[256];
        int          errors;
        int          inputs;
        int          results;

        function new();
            byte_t syms[TREE_ENTRIES];
            string paths[TREE_ENTRIES];
            int    n;
            syms = '{"E", "T", "I", "A", "N", "M", "S", "U", "R", "W", "D", "K", "G",
                     "O", "H", "V", "F", "#", "L", "#", "P", "J", "B", "X", "C", "Y",
                     "Z", "Q", "#", "#", "5", "4", "3", "#", "2", "&", "#", "+", "#",
                     "1", "6", "=", "/", "#", "(", "7", "#", 8'd165, "8", "9", "0",
                     "?", "_", 8'd34, ".", "@", 8'd39, "-", ";", "!", ")", ",", ":"};
            paths = '{".", "-", "..", ".-", "-.", "--", "...", "..-", ".-.", ".--",
                      "-..", "-.-", "--.", "---", "....", "...-", "..-.", "..--",
                      ".-..", ".-.-", ".--.", ".---", "-...", "-..-", "-.-.", "-.--",
                      "--..", "--.-", "---.", "----", ".....", "....-", "...--",
                      "..--.", "..---", ".-...", ".-..-", ".-.-.", ".--.-", ".----",
                      "-....", "-...-", "-..-.", "-.-.-", "-.--.", "--...", "--..-",
                      "--.--", "---..", "----.", "-----", "..--..", "..--.-",
                      ".-..-.", ".-.-.-", ".--.-.", ".----.", "-....-", "-.-.-.",
                      "-.-.--", "-.--.-", "--..--", "---..."};
            foreach (node_used[i])
                node_used[i] = 1'b0;
            foreach (char_known[i])
                char_known[i] = 1'b0;
            for (int k = 0; k < TREE_ENTRIES; k++)
            begin
                n = 0;
                for (int j = 0; j < paths[k].len(); j++)
                    n = 2 * n + ((paths[k][j] == CH_DASH) ? 2 : 1);
                if (!node_used[n])
                begin
                    node_used[n] = 1'b1;
                    node_char[n] = syms[k];
                end
                // first entry wins, as the table is searched in order
                if (!char_known[syms[k]])
                begin
                    char_known[syms[k]] = 1'b1;
                    char_code[syms[k]]  = paths[k];
                end
            end
            dir      = DIR_ENCODE;
            node     = '0;
            bad_code = 1'b0;
            word_gap = 1'b0;
            errors   = 0;
            inputs   = 0;
            results  = 0;
        endfunction

        function void set_direction(codec_dir_e d);
            dir = d;
        endfunction

        function int pending();
            return awaited_q.size();
        endfunction

        function int depth_of(int n);
            int d;
            d = 0;
            while (n > 0)
            begin
                n = (n - 1) / 2;
                d++;
            end
            return d;
        endfunction

        function void push_sym(byte_t b);
            morse_sym_t s;
            s.out_byte = b;
            s.last     = 1'b0;
            awaited_q.push_back(s);
        endfunction

        // Predict the results of one accepted item.
        function void note_input(byte_t b);
            int    first;
            int    len;
            int    child;
            byte_t c;
            first = awaited_q.size();
            inputs++;
            if (dir == DIR_ENCODE)
            begin
                if (b == CH_HASH || b == CH_SPACE)
                    push_sym(CH_SPACE);
                else if (char_known[b])
                begin
                    len = char_code[b].len();
                    if (len > MAX_CODE_LEN)
                        len = MAX_CODE_LEN;
                    for (int j = 0; j < len; j++)
                        push_sym(char_code[b][j]);
                    push_sym(CH_SPACE);
                end
            end
            else if (b == CH_DOT || b == CH_DASH)
            begin
                word_gap = 1'b0;
                if (!bad_code)
                begin
                    child = 2 * int'(node) + ((b == CH_DASH) ? 2 : 1);
                    if (depth_of(node) < MAX_CODE_LEN && child < NODE_COUNT &&
                        node_used[child])
                        node = node_t'(child);
                    else
                        bad_code = 1'b1;
                end
            end
            else if (b == CH_SPACE)
            begin
                if (word_gap)
                begin
                    push_sym(CH_SPACE);
                    word_gap = 1'b0;
                end
                else
                begin
                    c = CH_HASH;
                    if (!bad_code && node != 0 && node_used[node])
                        c = node_char[node];
                    push_sym(c);
                    node     = '0;
                    bad_code = 1'b0;
                    word_gap = 1'b1;
                end
            end
            if (awaited_q.size() > first)
                awaited_q[awaited_q.size() - 1].last = 1'b1;
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check(byte_t b, logic lst);
            morse_sym_t e;
            results++;
            if (awaited_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result out_byte=%0d last=%0b", $time, b, lst);
                return;
            end
            e = awaited_q.pop_front();
            if (b !== e.out_byte)
            begin
                errors++;
                $display("%0t: out_byte mismatch, expected %0d, actual %0d",
                         $time, e.out_byte, b);
            end
            if (lst !== e.last)
            begin
                errors++;
                $display("%0t: last mismatch, expected %0b, actual %0b",
                         $time, e.last, lst);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_data;

    mc_in_if  in_chan();
    mc_out_if out_chan();

    morse_codec_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    codec_scoreboard sb;
    int  cycles;
    int  cfg_writes;
    bit  calm;      // no idling on either side while set
    bit  hold_off;  // asks the receiver for one long hold-off

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offer one item at a falling edge, hold it until it is taken.
    task automatic send_byte(input byte_t b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_chan.valid   <= 1'b1;
        in_chan.in_byte <= b;
        do
            @(posedge clk);
        while (!in_chan.ready);
        sb.note_input(b);
    endtask

    // Stop offering, then wait until every prediction has been met and
    // items that cause no result have had time to pass through.
    task automatic wait_idle();
        @(negedge clk);
        in_chan.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_direction(input codec_dir_e d);
        wait_idle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= d;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.set_direction(d);
        cfg_writes++;
    endtask

    // Encode traffic: mostly characters of the tree, some spaces, hashes
    // and arbitrary bytes.
    task automatic random_encode(input int count);
        int    r;
        byte_t b;
        byte_t known[$];
        for (int i = 0; i < 256; i++)
            if (sb.char_known[i])
                known.push_back(byte_t'(i));
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 78)
                b = known[$urandom_range(0, known.size() - 1)];
            else if (r < 85)
                b = CH_SPACE;
            else if (r < 88)
                b = CH_HASH;
            else
                b = byte_t'($urandom_range(0, 255));
            send_byte(b);
        end
    endtask

    // Decode traffic: well-formed codes of random content closed by a
    // space, now and then a word space, an over-long code or a noise byte.
    task automatic random_decode(input int count);
        int start;
        int len;
        start = sb.inputs;
        while (sb.inputs - start < count)
        begin
            if ($urandom_range(0, 99) < 10)
                send_byte(byte_t'($urandom_range(0, 255)));
            else
            begin
                len = ($urandom_range(0, 99) < 8) ? $urandom_range(7, 8)
                                                  : $urandom_range(1, 6);
                for (int j = 0; j < len; j++)
                    send_byte($urandom_range(0, 1) ? CH_DASH : CH_DOT);
                send_byte(CH_SPACE);
                if ($urandom_range(0, 99) < 15)
                    send_byte(CH_SPACE);
            end
        end
    endtask

    // Receiver: bursts of ready broken by gaps, and one long hold-off on
    // request, counted here while the sender keeps offering items.
    initial
    begin : receiver
        int gap;
        int burst;
        out_chan.ready = 1'b0;
        burst = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_chan.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
            end
            else if (burst > 0)
            begin
                out_chan.ready <= 1'b1;
                burst--;
            end
            else
            begin
                gap   = pick_gap();
                burst = $urandom_range(1, 16);
                if (gap == 0)
                    out_chan.ready <= 1'b1;
                else
                begin
                    out_chan.ready <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
    end

    // Results are taken at the rising edge on valid and ready.
    always @(posedge clk)
    begin
        if (rst_n && out_chan.valid && out_chan.ready)
            sb.check(out_chan.out_byte, out_chan.last);
    end

    // Watchdog.
    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        sb              = new();
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = 1'b0;
        in_chan.valid   = 1'b0;
        in_chan.in_byte = '0;
        calm            = 1'b0;
        hold_off        = 1'b0;
        cfg_writes      = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Encode, directed: shortest code, a six-symbol code, five dashes,
        // space, hash, zero and all-ones bytes, the top-bit character, the
        // apostrophe and a byte outside the tree.
        write_direction(DIR_ENCODE);
        send_byte("E");
        send_byte("?");
        send_byte("0");
        send_byte(CH_SPACE);
        send_byte(CH_HASH);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'd165);
        send_byte(8'd39);
        send_byte("a");

        // Decode, directed: a space at the root gives a hash, a second
        // space a word space; a normal letter; a code descending past the
        // depth limit; ignored bytes.
        write_direction(DIR_DECODE);
        send_byte(CH_SPACE);
        send_byte(CH_SPACE);
        send_byte(CH_DOT);
        send_byte(CH_DASH);
        send_byte(CH_SPACE);
        send_byte(CH_DASH);
        send_byte(CH_DOT);
        send_byte(CH_DASH);
        send_byte(CH_DOT);
        send_byte(CH_DASH);
        send_byte(CH_DASH);
        send_byte(CH_DOT);
        send_byte(CH_SPACE);
        send_byte(8'hFF);
        send_byte("x");

        // Random phases; the first one starts with the receiver held off
        // so the block backs up and stalls its input.
        write_direction(DIR_ENCODE);
        hold_off = 1'b1;
        random_encode(70);
        write_direction(DIR_DECODE);
        random_decode(75);
        // half-built decode state must survive an encode phase
        send_byte(CH_DASH);
        send_byte(CH_DOT);
        write_direction(DIR_ENCODE);
        calm = 1'b1;
        random_encode(60);
        calm = 1'b0;
        write_direction(DIR_DECODE);
        random_decode(75);

        @(negedge clk);
        in_chan.valid <= 1'b0;
        calm = 1'b1;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("Run covered %0d items in and %0d results out over %0d direction writes,",
                 sb.inputs, sb.results, cfg_writes);
        $display("both directions, directed corner codes and random stall patterns.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
rtl/mc_pkg.sv
rtl/mc_in_if.sv
rtl/mc_out_if.sv
rtl/mc_front.sv
rtl/mc_emit.sv
rtl/morse_codec_unit.sv
test/morse_codec_unit_tb.sv
